// ===== src/cartridge_chr_bank_mapper_assert.svh =====
// Assertion macros shared by the mapper's RTL files.
`ifndef CARTRIDGE_CHR_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_CHR_BANK_MAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCBM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ccbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccbm_pkg;

   localparam int NT_DEPTH  = 2048;
   localparam int PAL_DEPTH = 32;
   localparam int NT_AW     = $clog2(NT_DEPTH);
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int IDX_W     = 13;
   localparam int ROM_AW    = 22;

   localparam logic [1:0] FUNC_CPU_RD = 2'd0;
   localparam logic [1:0] FUNC_CPU_WR = 2'd1;
   localparam logic [1:0] FUNC_PPU_RD = 2'd2;
   localparam logic [1:0] FUNC_PPU_WR = 2'd3;

   localparam logic [1:0] CSR_PRG_BANKS   = 2'd0;
   localparam logic [1:0] CSR_CHR_BANKS   = 2'd1;
   localparam logic [1:0] CSR_VERT_MIRROR = 2'd2;
   localparam logic [1:0] CSR_WRAM_BYTES  = 2'd3;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_WRAM,
      ACC_NT,
      ACC_PAL,
      ACC_ROM,
      ACC_BANK
   } ccbm_kind_type;

   typedef struct packed {
      ccbm_kind_type     kind;
      logic              write;
      logic [IDX_W-1:0]  index;
      logic [ROM_AW-1:0] rom_addr;
      logic [7:0]        wdata;
   } ccbm_access_type;

   typedef struct packed {
      logic [1:0]  prg_banks;
      logic [7:0]  chr_banks;
      logic        vertical_mirroring;
      logic [13:0] work_ram_bytes;
   } ccbm_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_DIVIDE
   } ccbm_state_type;

endpackage

`default_nettype wire

// ===== src/ccbm_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccbm_decode (
   input  wire logic [1:0]                func,
   input  wire logic [15:0]               addr,
   input  wire logic [7:0]                wdata,
   input  wire ccbm_pkg::ccbm_cfg_type    cfg,
   input  wire logic [7:0]                chr_bank,
   output ccbm_pkg::ccbm_access_type      acc
);
   import ccbm_pkg::*;

   logic        prg2;
   logic [13:0] ppu_a;
   logic [13:0] wram_mask;
   logic [8:0]  chr_base;
   logic        nt_hi;
   logic [4:0]  pal_idx;

   // A program bank count of 2 or 3 means two banks; 0 or 1 means one.
   assign prg2      = cfg.prg_banks[1];
   assign ppu_a     = addr[13:0];
   assign wram_mask = cfg.work_ram_bytes - 14'd1;
   assign chr_base  = {1'b0, chr_bank} + (prg2 ? 9'd4 : 9'd2);
   assign nt_hi     = cfg.vertical_mirroring ? ppu_a[10] : ppu_a[11];

   always_comb begin
      pal_idx = ppu_a[4:0];
      if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
         pal_idx[4] = 1'b0;
      end
   end

   always_comb begin
      acc          = '0;
      acc.kind     = ACC_NONE;
      acc.write    = func[0];
      acc.wdata    = wdata;
      unique case (func) inside
         FUNC_CPU_RD, FUNC_CPU_WR: begin
            if (addr[15:13] == 3'b011) begin
               if (cfg.work_ram_bytes != 14'd0) begin
                  acc.kind  = ACC_WRAM;
                  acc.index = addr[12:0] & wram_mask[12:0];
               end
            end else if (addr[15]) begin
               if (func[0]) begin
                  acc.kind = ACC_BANK;
               end else begin
                  acc.kind     = ACC_ROM;
                  acc.rom_addr = {7'd0, prg2 & addr[14], addr[13:0]};
               end
            end
         end
         FUNC_PPU_RD, FUNC_PPU_WR: begin
            if (!ppu_a[13]) begin
               // Pattern table: character ROM, writes are dropped.
               if (!func[0]) begin
                  acc.kind     = ACC_ROM;
                  acc.rom_addr = {chr_base, ppu_a[12:0]};
               end
            end else if (ppu_a[13:8] != 6'h3F) begin
               acc.kind  = ACC_NT;
               acc.index = {2'b00, nt_hi, ppu_a[9:0]};
            end else begin
               acc.kind  = ACC_PAL;
               acc.index = {8'd0, pal_idx};
            end
         end
         default: begin
            acc.kind = ACC_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/ccbm_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccbm_rem (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [7:0] dividend,
   input  wire logic [7:0] divisor,
   output logic            busy,
   output logic            done,
   output logic [7:0]      remainder
);
   import ccbm_pkg::*;

   localparam int STEPS = 8;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       quo_ff, quo_in;
   logic [7:0]       divisor_ff, divisor_in;
   logic [8:0]       trial;
   logic [8:0]       diff;

   // One restoring step per cycle: shift in the next dividend bit and
   // subtract the divisor when it fits.
   assign trial = {rem_ff, quo_ff[7]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, divisor_ff}) ? diff[7:0] : trial[7:0];
         quo_in = {quo_ff[6:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

`include "cartridge_chr_bank_mapper_assert.svh"

   `CCBM_ASSERT_NEXT(a_start_busy, start, busy_ff, "remainder unit did not start")
   `CCBM_ASSERT_NOW(a_rem_range, done_ff && (divisor_ff != 8'd0), rem_ff < divisor_ff, "remainder not below divisor")
   `CCBM_ASSERT_NOW(a_no_restart, busy_ff, !start, "remainder unit restarted while busy")

endmodule

`default_nettype wire

// ===== src/ccbm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccbm_store #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire ccbm_pkg::ccbm_access_type acc,
   output logic                           clearing,
   output logic [7:0]                     rdata
);
   import ccbm_pkg::*;

   localparam int WA        = $clog2(WORK_RAM_DEPTH);
   localparam int CLR_DEPTH = (WORK_RAM_DEPTH > NT_DEPTH) ? WORK_RAM_DEPTH : NT_DEPTH;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);
   localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);

   logic [7:0] wram [WORK_RAM_DEPTH];
   logic [7:0] nt   [NT_DEPTH];
   logic [7:0] pal  [PAL_DEPTH];

   logic              clr_busy_ff, clr_busy_in;
   logic [CLR_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0]        wram_q_ff, nt_q_ff, pal_q_ff;
   ccbm_kind_type     kind_ff;

   logic [WA-1:0]     wram_idx;
   logic [NT_AW-1:0]  nt_idx;
   logic [PAL_AW-1:0] pal_idx;
   logic              rd_en;
   logic              wr_wram, wr_nt, wr_pal;

   assign wram_idx = acc.index[WA-1:0];
   assign nt_idx   = acc.index[NT_AW-1:0];
   assign pal_idx  = acc.index[PAL_AW-1:0];
   assign rd_en    = en && !acc.write;
   assign wr_wram  = en && acc.write && (acc.kind == ACC_WRAM);
   assign wr_nt    = en && acc.write && (acc.kind == ACC_NT);
   assign wr_pal   = en && acc.write && (acc.kind == ACC_PAL);

   // After reset every memory is swept to zero, one address per cycle.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + CLR_AW'(1);
         if (clr_cnt_ff == CLR_LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         wram[clr_cnt_ff[WA-1:0]] <= '0;
      end else if (wr_wram) begin
         wram[wram_idx] <= acc.wdata;
      end
      if (rd_en) begin
         wram_q_ff <= wram[wram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         nt[clr_cnt_ff[NT_AW-1:0]] <= '0;
      end else if (wr_nt) begin
         nt[nt_idx] <= acc.wdata;
      end
      if (rd_en) begin
         nt_q_ff <= nt[nt_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         pal[clr_cnt_ff[PAL_AW-1:0]] <= '0;
      end else if (wr_pal) begin
         pal[pal_idx] <= acc.wdata;
      end
      if (rd_en) begin
         pal_q_ff <= pal[pal_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= acc.kind;
      end
   end

   always_comb begin
      case (kind_ff)
         ACC_WRAM: rdata = wram_q_ff;
         ACC_NT:   rdata = nt_q_ff;
         ACC_PAL:  rdata = pal_q_ff;
         default:  rdata = '0;
      endcase
   end

   assign clearing = clr_busy_ff;

endmodule

`default_nettype wire

// ===== src/cartridge_chr_bank_mapper.sv =====
// Flow: an accepted request moves to the access state, or for a bank-register write first
// to the divide state until the bit-serial remainder unit is done; the response is registered
// once the output register is free. A new request is taken only after the previous response
// has been loaded. A stalled response holds off the next request.
// Reset: configuration returns to its defaults and the bank register to zero, then the RAMs
// are swept to zero over max(WORK_RAM_DEPTH, 2048) addresses with req_ready held low.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_chr_bank_mapper #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_addr,
   input  wire logic [7:0]  req_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_rdata,
   output logic             rsp_rom_read,
   output logic [21:0]      rsp_rom_addr,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_wdata
);
   import ccbm_pkg::*;

   ccbm_cfg_type    cfg_ff;
   logic [7:0]      chr_bank_ff;
   ccbm_state_type  state_ff, state_in;
   ccbm_access_type acc_ff;
   ccbm_access_type dec;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_rdata_ff;
   logic        rsp_rom_read_ff;
   logic [21:0] rsp_rom_addr_ff;

   logic        accept;
   logic        clearing;
   logic [7:0]  store_rdata;
   logic        out_free;
   logic        load_rsp;
   logic        div_start;
   logic [7:0]  div_dividend;
   logic        div_busy;
   logic        div_done;
   logic [7:0]  div_rem;
   logic        ram_read;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prg_banks          <= 2'd2;
         cfg_ff.chr_banks          <= 8'd4;
         cfg_ff.vertical_mirroring <= 1'b0;
         cfg_ff.work_ram_bytes     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PRG_BANKS:   cfg_ff.prg_banks          <= csr_wdata[1:0];
            CSR_CHR_BANKS:   cfg_ff.chr_banks          <= csr_wdata[7:0];
            CSR_VERT_MIRROR: cfg_ff.vertical_mirroring <= csr_wdata[0];
            CSR_WRAM_BYTES:  cfg_ff.work_ram_bytes     <= csr_wdata;
            default:         cfg_ff.prg_banks          <= cfg_ff.prg_banks;
         endcase
      end
   end

   ccbm_decode u_decode (
      .func     (req_func),
      .addr     (req_addr),
      .wdata    (req_wdata),
      .cfg      (cfg_ff),
      .chr_bank (chr_bank_ff),
      .acc      (dec)
   );

   ccbm_store #(
      .WORK_RAM_DEPTH (WORK_RAM_DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .en       (accept),
      .acc      (dec),
      .clearing (clearing),
      .rdata    (store_rdata)
   );

   // With four or fewer banks only the low two bits of the written byte count.
   assign div_dividend = (cfg_ff.chr_banks <= 8'd4) ? {6'd0, req_wdata[1:0]} : req_wdata;
   assign div_start    = accept && (dec.kind == ACC_BANK);

   ccbm_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cfg_ff.chr_banks),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !clearing;
            if (req_valid && !clearing) begin
               state_in = (dec.kind == ACC_BANK) ? ST_DIVIDE : ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ACCESS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chr_bank_ff <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DIVIDE) && div_done) begin
            chr_bank_ff <= (cfg_ff.chr_banks == 8'd0) ? 8'd0 : div_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= dec;
      end
   end

   assign ram_read = !acc_ff.write &&
                     ((acc_ff.kind == ACC_WRAM) || (acc_ff.kind == ACC_NT) ||
                      (acc_ff.kind == ACC_PAL));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_rdata_ff    <= ram_read ? store_rdata : 8'd0;
         rsp_rom_read_ff <= (acc_ff.kind == ACC_ROM);
         rsp_rom_addr_ff <= (acc_ff.kind == ACC_ROM) ? acc_ff.rom_addr : 22'd0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rdata    = rsp_rdata_ff;
   assign rsp_rom_read = rsp_rom_read_ff;
   assign rsp_rom_addr = rsp_rom_addr_ff;

`include "cartridge_chr_bank_mapper_assert.svh"

   `CCBM_ASSERT_NOW(a_divide_tracks_unit, state_ff == ST_DIVIDE, div_busy || div_done, "bank write waiting on idle remainder unit")
   `CCBM_ASSERT_NOW(a_rom_no_data, rsp_valid_ff && rsp_rom_read_ff, rsp_rdata_ff == 8'd0, "ROM response carries RAM data")
   `CCBM_ASSERT_NOW(a_clear_quiet, clearing, (state_ff == ST_IDLE) && !rsp_valid_ff, "request in flight during RAM clear")

endmodule

`default_nettype wire

// ===== test/cartridge_chr_bank_mapper_tb.sv =====
`timescale 1ns / 1ps

module cartridge_chr_bank_mapper_tb;
   import ccbm_pkg::*;

   localparam int WRAM_DEPTH = 8192;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        rom_read;
      logic [21:0] rom_addr;
   } mapper_reply_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_CPU_RD;
   logic [15:0] req_addr = 16'h0000;
   logic [7:0]  req_wdata = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_rdata;
   logic        rsp_rom_read;
   logic [21:0] rsp_rom_addr;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PRG_BANKS;
   logic [13:0] csr_wdata = 14'd0;

   // Mapper configuration and storage as the predictor sees them.
   logic [1:0]  cfg_prg_banks = 2'd2;
   logic [7:0]  cfg_chr_banks = 8'd4;
   logic        cfg_vertical = 1'b0;
   logic [13:0] cfg_wram_bytes = 14'd0;
   logic [7:0]  chr_bank_sel = 8'd0;
   logic [7:0]  work_ram_mem [WRAM_DEPTH] = '{default: 8'h00};
   logic [7:0]  nt_mem [NT_DEPTH] = '{default: 8'h00};
   logic [7:0]  pal_mem [PAL_DEPTH] = '{default: 8'h00};

   mapper_reply_type pending_replies [$];

   rx_pattern_type rx_mode = RX_ALWAYS;
   logic [4:0]  rx_phase = '0;
   bit          steady_sender = 1'b1;
   int          burst_left = 0;
   int          failures = 0;
   int          requests_sent = 0;
   int          replies_checked = 0;
   int          bank_writes = 0;
   int          rom_fetches = 0;
   int          settings_used = 0;

   cartridge_chr_bank_mapper #(.WORK_RAM_DEPTH(WRAM_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_addr(req_addr),
      .req_wdata(req_wdata),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_rdata(rsp_rdata),
      .rsp_rom_read(rsp_rom_read),
      .rsp_rom_addr(rsp_rom_addr),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mapper_reply_type predict_bus_access(input logic [1:0] func,
                                                            input logic [15:0] addr,
                                                            input logic [7:0] wdata);
      mapper_reply_type r;
      int unsigned prg, pa, idx, span, cpu_addr, bank;
      r = '0;
      prg = (cfg_prg_banks == 2'd0) ? 1 : (cfg_prg_banks == 2'd3) ? 2 : cfg_prg_banks;
      cpu_addr = addr;
      span = cfg_wram_bytes;
      bank = chr_bank_sel;
      idx = ((cpu_addr - 32'h6000) & (span - 1)) & (WRAM_DEPTH - 1);
      case (func)
         FUNC_CPU_RD: begin
            if ((addr & 16'hE000) == 16'h6000) begin
               if (span != 0) r.rdata = work_ram_mem[idx];
            end else if (addr >= 16'h8000) begin
               r.rom_read = 1'b1;
               r.rom_addr = 22'((cpu_addr & 32'h7FFF) & (prg * 16384 - 1));
            end
         end
         FUNC_CPU_WR: begin
            if ((addr & 16'hE000) == 16'h6000) begin
               if (span != 0) work_ram_mem[idx] = wdata;
            end else if (addr >= 16'h8000) begin
               bank_writes++;
               // Small carts only decode the two low data bits.
               if (cfg_chr_banks == 8'd0) chr_bank_sel = 8'd0;
               else if (cfg_chr_banks <= 8'd4)
                  chr_bank_sel = 8'((int'(wdata) & 3) % int'(cfg_chr_banks));
               else chr_bank_sel = 8'(int'(wdata) % int'(cfg_chr_banks));
            end
         end
         default: begin
            pa = cpu_addr & 32'h3FFF;
            if (pa < 32'h2000) begin
               if (func == FUNC_PPU_RD) begin
                  r.rom_read = 1'b1;
                  r.rom_addr = 22'(prg * 16384 + bank * 8192 + (pa & 32'h1FFF));
               end
            end else if (pa < 32'h3F00) begin
               idx = (cfg_vertical ? (pa & 32'h400) : ((pa >> 1) & 32'h400)) | (pa & 32'h3FF);
               idx = idx & (NT_DEPTH - 1);
               if (func == FUNC_PPU_WR) nt_mem[idx] = wdata;
               else r.rdata = nt_mem[idx];
            end else begin
               idx = pa & 32'h1F;
               // Sprite backdrop entries share storage with the background ones.
               if ((idx & 32'h13) == 32'h10) idx = idx & 32'h0F;
               if (func == FUNC_PPU_WR) pal_mem[idx] = wdata;
               else r.rdata = pal_mem[idx];
            end
         end
      endcase
      if (r.rom_read) rom_fetches++;
      return r;
   endfunction

   task automatic send_access(input logic [1:0] func, input logic [15:0] addr,
                              input logic [7:0] wdata);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = steady_sender ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= func;
      req_addr <= addr;
      req_wdata <= wdata;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_replies.push_back(predict_bus_access(func, addr, wdata));
      requests_sent++;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
      // Leave the mapper idle for a while before anything else is written.
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [13:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_PRG_BANKS:   cfg_prg_banks = value[1:0];
         CSR_CHR_BANKS:   cfg_chr_banks = value[7:0];
         CSR_VERT_MIRROR: cfg_vertical = value[0];
         CSR_WRAM_BYTES:  cfg_wram_bytes = value;
         default: ;
      endcase
   endtask

   task automatic configure_mapper(input logic [1:0] prg, input logic [7:0] chr,
                                   input logic vert, input logic [13:0] wram);
      drain_replies();
      write_register(CSR_PRG_BANKS, 14'(prg));
      write_register(CSR_CHR_BANKS, 14'(chr));
      write_register(CSR_VERT_MIRROR, 14'(vert));
      write_register(CSR_WRAM_BYTES, wram);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic test_directed_cases();
      steady_sender = 1'b1;
      rx_mode = RX_ALWAYS;
      // Reset defaults: two program banks, four character banks, no work RAM.
      send_access(FUNC_CPU_RD, 16'h0000, 8'h00);
      send_access(FUNC_CPU_WR, 16'h5FFF, 8'hAA);
      send_access(FUNC_CPU_WR, 16'h6000, 8'h5A);
      send_access(FUNC_CPU_RD, 16'h6000, 8'h00);
      send_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
      send_access(FUNC_CPU_WR, 16'h8000, 8'hFF);
      send_access(FUNC_PPU_RD, 16'h1FFF, 8'h00);
      send_access(FUNC_PPU_WR, 16'h0000, 8'h77);
      send_access(FUNC_PPU_WR, 16'h2000, 8'hFF);
      send_access(FUNC_PPU_RD, 16'h2400, 8'h00);
      send_access(FUNC_PPU_RD, 16'hE400, 8'h00);
      send_access(FUNC_PPU_WR, 16'h3F10, 8'h3C);
      send_access(FUNC_PPU_RD, 16'h3F00, 8'h00);
      send_access(FUNC_PPU_WR, 16'h3F1F, 8'hC3);
      send_access(FUNC_PPU_RD, 16'hFFFF, 8'h00);
      send_access(FUNC_PPU_RD, 16'h3EFF, 8'h00);
      configure_mapper(2'd0, 8'd0, 1'b1, 14'd8192);
      send_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
      send_access(FUNC_CPU_WR, 16'h8000, 8'hFF);
      send_access(FUNC_PPU_RD, 16'h0000, 8'h00);
      send_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF);
      send_access(FUNC_CPU_RD, 16'h7FFF, 8'h00);
      send_access(FUNC_PPU_WR, 16'h2400, 8'h11);
      send_access(FUNC_PPU_RD, 16'h2C00, 8'h00);
      configure_mapper(2'd3, 8'd255, 1'b0, 14'd16383);
      send_access(FUNC_CPU_WR, 16'hFFFF, 8'hFE);
      send_access(FUNC_PPU_RD, 16'h1000, 8'h00);
   endtask

   task automatic test_bank_switching();
      logic [7:0] bank_counts [6] = '{8'd1, 8'd2, 8'd5, 8'd255, 8'd0, 8'd4};
      steady_sender = 1'b0;
      rx_mode = RX_RANDOM;
      foreach (bank_counts[s]) begin
         configure_mapper(2'($urandom_range(0, 3)), bank_counts[s], 1'($urandom), 14'd0);
         repeat (5) begin
            send_access(FUNC_CPU_WR, 16'h8000 | 16'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 2))
               send_access(FUNC_PPU_RD, 16'($urandom) & ~16'h2000, 8'($urandom));
            send_access(FUNC_CPU_RD, 16'h8000 | 16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic test_work_ram();
      logic [13:0] sizes [8] = '{14'd0, 14'd1, 14'd2, 14'd1024, 14'd8192, 14'd16383,
                                 14'd12000, 14'd4096};
      logic [15:0] addr;
      rx_mode = RX_BURSTY;
      foreach (sizes[s]) begin
         steady_sender = s[0];
         configure_mapper(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), sizes[s]);
         repeat (5) begin
            addr = 16'h6000 | (16'($urandom) & 16'h1FFF);
            send_access(FUNC_CPU_WR, addr, 8'($urandom));
            send_access(FUNC_CPU_RD, addr, 8'($urandom));
            if ($urandom_range(0, 1))
               send_access(FUNC_CPU_RD, 16'h6000 | (16'($urandom) & 16'h1FFF), 8'h00);
         end
      end
   endtask

   task automatic test_nametable_mirroring();
      logic [15:0] base, alias_addr;
      rx_mode = RX_RANDOM;
      for (int s = 0; s < 4; s++) begin
         steady_sender = (s == 2);
         configure_mapper(2'($urandom_range(1, 2)), 8'd4, 1'(s), 14'd0);
         repeat (8) begin
            base = 16'h2000 + 16'($urandom_range(0, 16'h1EFF));
            alias_addr = base ^ (cfg_vertical ? 16'h0800 : 16'h0400);
            if ($urandom_range(0, 1)) alias_addr = alias_addr ^ 16'h1000;
            if (alias_addr >= 16'h3F00 || alias_addr < 16'h2000) alias_addr = base;
            send_access(FUNC_PPU_WR, base | (16'($urandom_range(0, 3)) << 14), 8'($urandom));
            send_access(FUNC_PPU_RD, alias_addr | (16'($urandom_range(0, 3)) << 14), 8'h00);
            if ($urandom_range(0, 3) == 0)
               send_access(FUNC_PPU_RD, base ^ 16'h0C00, 8'h00);
         end
      end
   endtask

   task automatic test_palette_mirrors();
      logic [15:0] addr;
      for (int s = 0; s < 2; s++) begin
         steady_sender = (s == 1);
         rx_mode = s ? RX_BURSTY : RX_ALWAYS;
         configure_mapper(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 14'd0);
         repeat (16) begin
            addr = 16'h3F00 | 16'($urandom_range(0, 255)) | (16'($urandom_range(0, 3)) << 14);
            send_access(FUNC_PPU_WR, addr, 8'($urandom));
            send_access(FUNC_PPU_RD, addr ^ ($urandom_range(0, 1) ? 16'h0010 : 16'h0000),
                        8'h00);
         end
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0] chr;
      for (int s = 0; s < 3; s++) begin
         steady_sender = (s == 0);
         rx_mode = rx_pattern_type'(s);
         chr = $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom);
         configure_mapper(2'($urandom_range(0, 3)), chr, 1'($urandom),
                          $urandom_range(0, 1) ? 14'(1 << $urandom_range(0, 13))
                                               : 14'($urandom));
         for (int i = 0; i < 40; i++) begin
            // Hold back mid-phase until the mapper has answered everything.
            if (i == 20) drain_replies();
            send_access(2'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      rx_phase <= rx_phase + 5'd1;
      case (rx_mode)
         RX_ALWAYS: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 9) < 6);
         default:   rsp_ready <= (rx_phase >= 5'd9);
      endcase
   end

   always @(posedge clock) begin : reply_checker
      mapper_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            if (rsp_rdata !== want.rdata) begin
               $error("rdata: expected %0h, got %0h", want.rdata, rsp_rdata);
               failures++;
            end
            if (rsp_rom_read !== want.rom_read) begin
               $error("rom_read: expected %0d, got %0d", want.rom_read, rsp_rom_read);
               failures++;
            end
            if (rsp_rom_addr !== want.rom_addr) begin
               $error("rom_addr: expected %0h, got %0h", want.rom_addr, rsp_rom_addr);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_bank_switching();
      test_work_ram();
      test_nametable_mirroring();
      test_palette_mirrors();
      test_random_traffic();
      drain_replies();
      repeat (20) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $error("%0d responses never arrived", pending_replies.size());
         failures++;
      end
      $display("Covered %0d CPU/PPU requests under %0d mapper settings, %0d responses checked.",
               requests_sent, settings_used, replies_checked);
      $display("Bank register writes: %0d, ROM fetches: %0d.", bank_writes, rom_fetches);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run timed out with %0d responses outstanding.", pending_replies.size());
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ccbm_pkg.sv
src/ccbm_decode.sv
src/ccbm_rem.sv
src/ccbm_store.sv
src/cartridge_chr_bank_mapper.sv
test/cartridge_chr_bank_mapper_tb.sv
